// ----- rtl/lmfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_pkg
// Shared types, constants and helper functions for the LIN master frame
// builder: payload structs, result slot codes, PID parity and checksum add.
// ----------------------------------------------------------------------------
package lmfb_pkg;

    // Default maximum number of data bytes per frame
    localparam int unsigned MAX_DATA_DEF = 8;

    // LIN sync field
    localparam logic [7:0] SYNC_BYTE = 8'h55;

    // Input item
    typedef struct packed {
        logic [5:0] frame_id;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       enhanced;
    } t_in;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_break;
        logic       overflow;
        logic       end_of_frame;
    } t_out;

    // Slot of a result within the run of one input item
    typedef enum logic [2:0] {
        POS_BREAK,
        POS_SYNC,
        POS_PID,
        POS_DATA,
        POS_CKSUM
    } t_pos;

    // Protected identifier: six-bit ID plus P0 (bit 6) and P1 (bit 7)
    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // 8-bit add with end-around carry
    function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

// ----- rtl/lmfb_result.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfb_result
// Works out the result for one slot of the current item, whether that slot
// closes the item's run, and the frame state left behind by the item.
// ----------------------------------------------------------------------------
module lmfb_result
    import lmfb_pkg::*;
#(
    parameter int unsigned MAX_DATA = MAX_DATA_DEF,
    localparam int unsigned CW = $clog2(MAX_DATA + 1)
) (
    input  t_in           i_item,
    input  t_pos          i_pos,
    input  logic          i_in_frame,
    input  logic [7:0]    i_acc,
    input  logic [CW-1:0] i_count,
    output t_out          o_res,
    output logic          o_last,
    output logic          o_nxt_in_frame,
    output logic [7:0]    o_nxt_acc,
    output logic [CW-1:0] o_nxt_count
);

    logic [7:0]    pid;
    logic [7:0]    base;
    logic [CW-1:0] cnt;
    logic          ovf;
    logic [7:0]    sum;
    logic [7:0]    acc_after;

    // Frame context as seen by this item (fresh on a frame's first byte)
    assign pid       = protect_id(i_item.frame_id);
    assign base      = i_in_frame ? i_acc : (i_item.enhanced ? pid : 8'd0);
    assign cnt       = i_in_frame ? i_count : '0;
    assign ovf       = (cnt >= CW'(MAX_DATA));
    assign sum       = add_carry(base, i_item.data_byte);
    assign acc_after = ovf ? base : sum;

    // Run ends at the checksum, or at the data slot when not last
    assign o_last = (i_pos == POS_CKSUM) || ((i_pos == POS_DATA) && !i_item.last_byte);

    // Result for the current slot
    always_comb begin
        o_res              = '0;
        o_res.end_of_frame = o_last;
        unique case (i_pos)
            POS_BREAK: o_res.is_break = 1'b1;
            POS_SYNC:  o_res.out_byte = SYNC_BYTE;
            POS_PID:   o_res.out_byte = pid;
            POS_DATA: begin
                o_res.out_byte = ovf ? 8'd0 : i_item.data_byte;
                o_res.overflow = ovf;
            end
            POS_CKSUM: o_res.out_byte = ~acc_after;
            default:   o_res.out_byte = 8'd0;
        endcase
    end

    // Frame state after the item
    always_comb begin
        if (i_item.last_byte) begin
            o_nxt_in_frame = 1'b0;
            o_nxt_acc      = 8'd0;
            o_nxt_count    = '0;
        end else begin
            o_nxt_in_frame = 1'b1;
            o_nxt_acc      = acc_after;
            o_nxt_count    = ovf ? cnt : cnt + CW'(1);
        end
    end

endmodule

// ----- rtl/lin_master_frame_builder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lin_master_frame_builder_core
// Turns a stream of data bytes into LIN master frame bytes: break, sync,
// protected identifier, data and inverted checksum (classic or enhanced).
// ----------------------------------------------------------------------------
// An item is registered in the stage, then each result in the result register.
// Throughput: one result per cycle while the output is not stalled; an item
// causes 1 to 5 results, and the next item is taken as its last one issues.
// Reset: synchronous active-low; clears stage, output valid and frame state.
module lin_master_frame_builder_core
    import lmfb_pkg::*;
#(
    parameter int unsigned MAX_DATA = MAX_DATA_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int unsigned CW = $clog2(MAX_DATA + 1);

    logic          r_stg_valid;
    t_in           r_stg_item;
    t_pos          r_pos;
    logic          r_in_frame;
    logic [7:0]    r_acc;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    t_out          r_out;

    t_out          res;
    logic          res_last;
    logic          nxt_in_frame;
    logic [7:0]    nxt_acc;
    logic [CW-1:0] nxt_count;
    logic          out_free;
    logic          stg_fire;
    logic          stg_done;
    logic          in_xfer;
    logic          n_in_frame;

    lmfb_result #(
        .MAX_DATA (MAX_DATA)
    ) u_result (
        .i_item         (r_stg_item),
        .i_pos          (r_pos),
        .i_in_frame     (r_in_frame),
        .i_acc          (r_acc),
        .i_count        (r_count),
        .o_res          (res),
        .o_last         (res_last),
        .o_nxt_in_frame (nxt_in_frame),
        .o_nxt_acc      (nxt_acc),
        .o_nxt_count    (nxt_count)
    );

    // Handshake control
    assign out_free   = !r_out_valid || i_out_ready;
    assign stg_fire   = r_stg_valid && out_free;
    assign stg_done   = stg_fire && res_last;
    assign o_in_ready = !r_stg_valid || stg_done;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign n_in_frame = stg_done ? nxt_in_frame : r_in_frame;

    // Stage: current item and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_pos       <= POS_BREAK;
        end else if (in_xfer) begin
            r_stg_valid <= 1'b1;
            r_pos       <= n_in_frame ? POS_DATA : POS_BREAK;
        end else if (stg_done) begin
            r_stg_valid <= 1'b0;
        end else if (stg_fire) begin
            r_pos <= t_pos'(3'(r_pos) + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_stg_item <= i_in_data;
        end
    end

    // Frame state, updated as an item's run completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_acc      <= 8'd0;
            r_count    <= '0;
        end else if (stg_done) begin
            r_in_frame <= nxt_in_frame;
            r_acc      <= nxt_acc;
            r_count    <= nxt_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stg_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
